[sv/fraction_reducer_defines.svh]
// ----------------------------------------------------------------------------
// Fraction reducer assertion macros
// Shared concurrent assertion forms for the fraction reducer checkers.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_DEFINES_SVH
`define FRACTION_REDUCER_DEFINES_SVH

// clocked assertion, quiet while reset is asserted
`define FRD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define FRD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/frd_pkg.sv]
// ----------------------------------------------------------------------------
// Fraction reducer package
// Sequencer state type and fixed field constants.
// ----------------------------------------------------------------------------
package frd_pkg;

    // result fields carry at most this many significant bits
    localparam int FIELD_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP,
        ST_GCD,
        ST_DIVN_GO,
        ST_DIVN_RUN,
        ST_DIVD_GO,
        ST_DIVD_RUN,
        ST_DONE
    } frd_state_t;

endpackage

[sv/frd_divider.sv]
// ----------------------------------------------------------------------------
// Fraction reducer serial divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module frd_divider #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[WIDTH-1]};
    assign diff      = rem_shift - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[WIDTH]) begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[sv/fraction_reducer.sv]
// ----------------------------------------------------------------------------
// Fraction reducer
// Reduces an unsigned fraction to lowest terms and reports the divisor.
// ----------------------------------------------------------------------------
// One fraction is in flight at a time; s_ready is high only while the
// sequencer is idle, and a finished result waits in the output register so
// the next fraction can be taken before it is collected. The gcd is found
// by the binary (Stein) method on one shared compare/subtract/shift step:
// shared powers of two are stripped first, then each step halves or
// subtract-halves one operand. The two quotients then come from one serial
// divider, numerator first. A zero denominator skips the gcd and division
// and goes straight to the output stage with all fields zero.
// ----------------------------------------------------------------------------
module fraction_reducer #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [WIDTH-1:0] s_numerator,
    input  logic [WIDTH-1:0] s_denominator,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WIDTH-1:0] m_reduced_numerator,
    output logic [WIDTH-1:0] m_reduced_denominator,
    output logic [WIDTH-1:0] m_common_divisor,
    output logic             m_zero_denominator
);

    import frd_pkg::*;

    localparam int KW = $clog2(WIDTH);
    localparam logic [WIDTH-1:0] OUT_MASK = ~({WIDTH{1'b1}} << FIELD_W);

    frd_state_t       state_reg, state_next;
    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] g_reg, g_next;
    logic [WIDTH-1:0] qn_reg, qn_next;
    logic [WIDTH-1:0] qd_reg, qd_next;
    logic             zero_reg, zero_next;
    logic             m_valid_reg;
    logic [WIDTH-1:0] rn_reg, rd_reg, cd_reg;
    logic             zd_reg;

    logic             ge;
    logic [WIDTH-1:0] diff;
    logic             div_start;
    logic [WIDTH-1:0] div_dividend;
    logic             div_done;
    logic [WIDTH-1:0] div_quotient;
    logic             out_free;
    logic             load_out;

    assign ge       = (a_reg >= b_reg);
    assign diff     = ge ? (a_reg - b_reg) : (b_reg - a_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        qn_next      = qn_reg;
        qd_next      = qd_reg;
        zero_next    = zero_reg;
        div_start    = 1'b0;
        div_dividend = num_reg;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    num_next  = s_numerator;
                    den_next  = s_denominator;
                    a_next    = s_numerator;
                    b_next    = s_denominator;
                    k_next    = '0;
                    zero_next = (s_denominator == '0);
                    if (s_denominator == '0) begin
                        g_next     = '0;
                        qn_next    = '0;
                        qd_next    = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_STRIP;
                    end
                end
            end
            ST_STRIP: begin
                if (a_reg != '0 && !a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else begin
                    state_next = ST_GCD;
                end
            end
            ST_GCD: begin
                if (a_reg == '0 || b_reg == '0) begin
                    g_next     = (a_reg | b_reg) << k_reg;
                    state_next = ST_DIVN_GO;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (ge) begin
                    a_next = diff >> 1;
                end else begin
                    b_next = diff >> 1;
                end
            end
            ST_DIVN_GO: begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                state_next   = ST_DIVN_RUN;
            end
            ST_DIVN_RUN: begin
                if (div_done) begin
                    qn_next    = div_quotient;
                    state_next = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO: begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                state_next   = ST_DIVD_RUN;
            end
            ST_DIVD_RUN: begin
                if (div_done) begin
                    qd_next    = div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
        g_reg    <= g_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
        zero_reg <= zero_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            rn_reg <= qn_reg & OUT_MASK;
            rd_reg <= qd_reg & OUT_MASK;
            cd_reg <= g_reg & OUT_MASK;
            zd_reg <= zero_reg;
        end
    end

    frd_divider #(
        .WIDTH(WIDTH)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid               = m_valid_reg;
    assign m_reduced_numerator   = rn_reg;
    assign m_reduced_denominator = rd_reg;
    assign m_common_divisor      = cd_reg;
    assign m_zero_denominator    = zd_reg;

endmodule

[sv/frd_checker.sv]
// ----------------------------------------------------------------------------
// Fraction reducer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "fraction_reducer_defines.svh"

module frd_checker #(
    parameter int WIDTH = 16
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [WIDTH-1:0] s_numerator,
    input logic [WIDTH-1:0] s_denominator,
    input logic             m_valid,
    input logic             m_ready,
    input logic [WIDTH-1:0] m_reduced_numerator,
    input logic [WIDTH-1:0] m_reduced_denominator,
    input logic [WIDTH-1:0] m_common_divisor,
    input logic             m_zero_denominator
);

    logic in_xfer;
    logic zero_den_in;
    logic zd_out;
    logic zd_fields_zero;
    logic zd_start;

    assign in_xfer        = s_valid && s_ready;
    assign zero_den_in    = (s_denominator == '0) && (s_numerator == s_numerator);
    assign zd_out         = m_valid && m_zero_denominator;
    assign zd_fields_zero = (m_reduced_numerator == '0) && (m_reduced_denominator == '0)
                            && (m_common_divisor == '0);
    assign zd_start       = in_xfer && zero_den_in && (!m_valid || m_ready);

    `FRD_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid, "m_valid after reset")
    `FRD_ASSERT(a_valid_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid, "m_valid dropped")
    `FRD_ASSERT(a_busy_after_xfer, aclk, aresetn, in_xfer |=> !s_ready, "ready during work")
    `FRD_ASSERT(a_zero_den_result, aclk, aresetn, zd_out |-> zd_fields_zero, "zero-den fields")
    `FRD_ASSERT(a_zero_den_fast, aclk, aresetn, zd_start |=> ##1 zd_out, "zero-den result late")

endmodule

bind fraction_reducer frd_checker #(.WIDTH(WIDTH)) u_frd_checker (.*);
